// ===== design/itt_pkg.sv =====
// Shared types, constants and helpers for the id timeout table.
package itt_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W   = 16;
  localparam int CNT_W  = 16;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // register indexes
  localparam logic REG_SEARCH_TIME = 1'b0;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [ID_W-1:0] timed_id;
  } in_word_t;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] finished_id;
    logic            last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic arrive;
    logic tick;
    logic hold_drop;
    logic load_exp;
    logic load_drop;
  } itt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic exp_any;
    logic exp_last;
    logic out_busy;
  } itt_stat_t;

  // index of the lowest set bit, zero when none
  function automatic logic [SLOT_W-1:0] lowest_set(input logic [SLOTS-1:0] m);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== design/itt_ctrl.sv =====
// Controller FSM: sequences arrivals, ticks, expiry drain and dropped words.
module itt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_opcode,
  input  logic             out_ready,
  input  itt_pkg::itt_stat_t stat,
  output itt_pkg::itt_cmd_t  cmd
);
  import itt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_DRAIN = 3'b010,
    S_DROP  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !stat.out_busy || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_TICK) begin
            cmd.tick  = 1'b1;
            state_nxt = S_DRAIN;
          end else if (stat.full) begin
            cmd.hold_drop = 1'b1;
            state_nxt     = S_DROP;
          end else begin
            cmd.arrive = 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if (!stat.exp_any) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          cmd.load_exp = 1'b1;
          if (stat.exp_last) state_nxt = S_IDLE;
        end
      end
      S_DROP: begin
        if (out_free) begin
          cmd.load_drop = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/itt_datapath.sv =====
// Datapath: slot table, per-slot countdowns, expiry mask and output register.
module itt_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  itt_pkg::itt_cmd_t         cmd,
  input  logic [itt_pkg::ID_W-1:0]  timed_id,
  input  logic [itt_pkg::CNT_W-1:0] search_time,
  input  logic                      out_ready,
  output itt_pkg::itt_stat_t        stat,
  output logic                      out_valid,
  output itt_pkg::out_word_t        out_data
);
  import itt_pkg::*;

  logic [SLOTS-1:0]  busy_r, busy_nxt;
  logic [SLOTS-1:0]  exp_r, exp_nxt;
  logic [ID_W-1:0]   owner_r [SLOTS];
  logic [CNT_W-1:0]  rem_r [SLOTS];
  logic [ID_W-1:0]   drop_id_r;
  logic              out_valid_r;
  out_word_t         out_data_r;

  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] exp_idx;
  logic [SLOTS-1:0]  exp_rest;
  logic [CNT_W-1:0]  duration;

  assign free_idx = lowest_set(~busy_r);
  assign exp_idx  = lowest_set(exp_r);
  assign exp_rest = exp_r & (exp_r - SLOTS'(1));
  // zero duration behaves as one tick
  assign duration = (search_time == '0) ? CNT_W'(1) : search_time;

  assign stat.full     = &busy_r;
  assign stat.exp_any  = |exp_r;
  assign stat.exp_last = (exp_rest == '0);
  assign stat.out_busy = out_valid_r;

  always_comb begin
    busy_nxt = busy_r;
    exp_nxt  = exp_r;
    if (cmd.tick) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (busy_r[i] && rem_r[i] <= CNT_W'(1)) begin
          busy_nxt[i] = 1'b0;
          exp_nxt[i]  = 1'b1;
        end
      end
    end
    if (cmd.arrive) busy_nxt[free_idx] = 1'b1;
    if (cmd.load_exp) exp_nxt = exp_rest;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      exp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      exp_r  <= exp_nxt;
      if (cmd.load_exp || cmd.load_drop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // slot payload, one countdown lane per slot
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (cmd.arrive && free_idx == SLOT_W'(i)) begin
        owner_r[i] <= timed_id;
        rem_r[i]   <= duration;
      end else if (cmd.tick && busy_r[i] && rem_r[i] > CNT_W'(1)) begin
        rem_r[i] <= rem_r[i] - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_drop) drop_id_r <= timed_id;
    if (cmd.load_exp) begin
      out_data_r.kind        <= KIND_DONE;
      out_data_r.finished_id <= owner_r[exp_idx];
      out_data_r.last        <= (exp_rest == '0);
    end else if (cmd.load_drop) begin
      out_data_r.kind        <= KIND_DROP;
      out_data_r.finished_id <= drop_id_r;
      out_data_r.last        <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/id_timeout_table_core.sv =====
// Top level of the id timeout table: config register, controller and datapath.
//
// Input words (in_valid/in_ready, in_data) are either an arrival, which
// claims the lowest free slot for timed_id with a count of search_time
// ticks, or a tick, which counts every busy slot down by one.
// Result words (out_valid/out_ready, out_data) report expired ids in slot
// order, the final one of a tick flagged by last, or an arrival dropped
// because every slot was busy (kind = 1, last = 1).
// An arrival that finds a slot leaves the controller idle. A tick enters the
// drain state, where the expiries drain one per cycle while the output is free,
// through the single output register, and returns to idle when nothing expires;
// a dropped arrival passes through the drop state. The first result of a tick
// or a drop is loaded from the drain or drop state. The input is held off only
// while a tick drains or a drop is pending, and a word is accepted while an
// earlier result still waits in the output register. A stalled receiver freezes
// the drain; nothing is lost. search_time sits at APB byte address 0; the user
// must write it only while idle, as the block does not check.
// Reset (synchronous, rst_n low) frees every slot and sets search_time to 1.
module id_timeout_table_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  itt_pkg::in_word_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output itt_pkg::out_word_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [itt_pkg::ADDR_W-1:0] paddr,
  input  logic [itt_pkg::DATA_W-1:0] pwdata,
  output logic [itt_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import itt_pkg::*;

  logic [CNT_W-1:0] search_time_r;
  logic             reg_hit;
  itt_cmd_t         cmd;
  itt_stat_t        stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_SEARCH_TIME) && (paddr[1:0] == 2'b00);
  assign prdata  = reg_hit ? DATA_W'(search_time_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_time_r <= CNT_W'(1);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      search_time_r <= pwdata[CNT_W-1:0];
    end
  end

  itt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_data.opcode),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  itt_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .timed_id    (in_data.timed_id),
    .search_time (search_time_r),
    .out_ready   (out_ready),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

// ===== dv/tb_id_timeout_table_core.sv =====
// Self-checking testbench for the id timeout table: random arrivals and ticks against a table model.
module tb_id_timeout_table_core;
  import itt_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 6;
  localparam logic [ADDR_W-1:0] ST_ADDR  = ADDR_W'(4 * REG_SEARCH_TIME);
  localparam logic [ADDR_W-1:0] BAD_ADDR = ADDR_W'(4);

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_word_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_word_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // table model
  logic              slot_used [SLOTS];
  logic [ID_W-1:0]   slot_id   [SLOTS];
  logic [CNT_W-1:0]  slot_left [SLOTS];
  logic [CNT_W-1:0]  duration;

  in_word_t  words_to_send [$];
  out_word_t pending_results [$];

  int  mismatches = 0;
  int  cyc = 0;
  int  hold_cnt = 0;
  logic rx_hold_go = 1'b0;
  logic quiet;

  id_timeout_table_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  // no idling on either side in this window
  assign quiet = (cyc >= 400) && (cyc < 900);

  function automatic void advance_table(input in_word_t w);
    int        last_slot;
    logic      placed;
    out_word_t r;
    placed = 1'b0;
    last_slot = -1;
    if (w.opcode == OP_ARRIVE) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed && !slot_used[i]) begin
          slot_used[i] = 1'b1;
          slot_id[i]   = w.timed_id;
          slot_left[i] = (duration == '0) ? CNT_W'(1) : duration;
          placed = 1'b1;
        end
      end
      if (!placed) begin
        r.kind = KIND_DROP;
        r.finished_id = w.timed_id;
        r.last = 1'b1;
        pending_results.push_back(r);
      end
    end else begin
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && slot_left[i] <= 1) last_slot = i;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i]) begin
          if (slot_left[i] <= 1) begin
            slot_left[i] = '0;
            slot_used[i] = 1'b0;
            r.kind = KIND_DONE;
            r.finished_id = slot_id[i];
            r.last = (i == last_slot);
            pending_results.push_back(r);
          end else begin
            slot_left[i] = slot_left[i] - 1'b1;
          end
        end
      end
    end
  endfunction

  function automatic in_word_t make_word(input logic op, input logic [ID_W-1:0] id);
    in_word_t w;
    w.opcode = op;
    w.timed_id = id;
    return w;
  endfunction

  function automatic in_word_t random_word(input int arrive_pct);
    logic [ID_W-1:0] id;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) id = '0;
    else if (pick == 1) id = '1;
    else id = ID_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 99) < arrive_pct) return make_word(OP_ARRIVE, id);
    return make_word(OP_TICK, id);
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) advance_table(in_data);
      if (!in_valid || in_ready) begin
        if (words_to_send.size() != 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
          in_data  <= words_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_go && hold_cnt < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 9);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: kind %0d id %h last %0d",
               out_data.kind, out_data.finished_id, out_data.last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          mismatches++;
        end
        if (out_data.finished_id !== want.finished_id) begin
          $error("finished_id: expected %h, got %h", want.finished_id, out_data.finished_id);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ST_ADDR) duration = data[CNT_W-1:0];
  endtask

  // sender idle and every result in, then a settling wait for a trailing arrival
  task automatic wait_drained();
    while (words_to_send.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [CNT_W-1:0] settings [4];
    duration = CNT_W'(1);
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_id[i]   = '0;
      slot_left[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset duration: two ids expire together, then a tick on an empty table
    words_to_send.push_back(make_word(OP_ARRIVE, 16'h0000));
    words_to_send.push_back(make_word(OP_ARRIVE, 16'hFFFF));
    words_to_send.push_back(make_word(OP_TICK, 16'hFFFF));
    words_to_send.push_back(make_word(OP_TICK, 16'h0000));
    wait_drained();

    // zero duration behaves as one tick
    cfg_write(ST_ADDR, 32'h0000_0000);
    words_to_send.push_back(make_word(OP_ARRIVE, 16'h1234));
    words_to_send.push_back(make_word(OP_TICK, 16'h0000));
    wait_drained();

    // upper data bits are dropped; an unmapped address is ignored
    cfg_write(ST_ADDR, 32'hABCD_0002);
    cfg_write(BAD_ADDR, 32'h0000_0009);
    for (int i = 0; i < SLOTS; i++)
      words_to_send.push_back(make_word(OP_ARRIVE, ID_W'($urandom_range(0, 65535))));
    words_to_send.push_back(make_word(OP_ARRIVE, 16'hA5A5));
    words_to_send.push_back(make_word(OP_TICK, 16'h5A5A));
    words_to_send.push_back(make_word(OP_TICK, 16'h0000));
    wait_drained();

    // random phases; the second one runs under a long receiver hold-off
    settings[0] = CNT_W'(3);
    settings[1] = CNT_W'(2);
    settings[2] = CNT_W'($urandom_range(1, 6));
    settings[3] = CNT_W'(1);
    for (int p = 0; p < 4; p++) begin
      cfg_write(ST_ADDR, {16'($urandom_range(0, 65535)), settings[p]});
      if (p == 1) rx_hold_go <= 1'b1;
      for (int i = 0; i < 6; i++) begin
        if (i % 7 == 0) begin
          // a burst of arrivals followed by ticks: drives the table towards full
          repeat ($urandom_range(3, 8)) words_to_send.push_back(random_word(100));
          repeat ($urandom_range(1, 3)) words_to_send.push_back(random_word(0));
        end else begin
          words_to_send.push_back(random_word(60));
        end
      end
      wait_drained();
    end

    // longest duration: nothing new expires, so the table fills and drops
    cfg_write(ST_ADDR, 32'h0000_FFFF);
    for (int i = 0; i < 22; i++) words_to_send.push_back(random_word(85));
    wait_drained();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/itt_pkg.sv
design/itt_ctrl.sv
design/itt_datapath.sv
design/id_timeout_table_core.sv
dv/tb_id_timeout_table_core.sv
